FILE: src/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit-bang sequencer package
// Shared types, codes and constants for the tick-driven I2C master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cms_pkg;

    // Transfer buffer geometry.
    localparam int BUF_DEPTH = 256;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);

    // Widths of the configuration port.
    localparam int CFG_IW = 1;
    localparam int CFG_DW = 9;

    // Phase landmarks of the bit sequencer.
    localparam logic [4:0] PH_ADDR_BITS_END = 5'd27;
    localparam logic [4:0] PH_DATA_BITS_END = 5'd24;
    localparam logic [4:0] PH_ADDR_ACK_END  = 5'd29;
    localparam logic [4:0] PH_FIRST_BIT     = 5'd3;

    // Item kinds carried by an input word.
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_LOAD  = 2'd2,
        KIND_READ  = 2'd3
    } item_kind_t;

    // Error codes reported with every result word.
    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_ADDR = 2'd1,
        ERR_DATA = 2'd2
    } err_code_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IW-1:0] {
        CFG_BYTE_COUNT = 1'b0,
        CFG_READ_MODE  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        item_kind_t  kind;
        logic        sda_in;
        logic [7:0]  buffer_index;
        logic [7:0]  buffer_byte;
    } in_item_t;

    typedef struct packed {
        logic        scl_out;
        logic        sda_out;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  error_code;
        logic [7:0]  buffer_read;
    } out_item_t;

    // A phase split into its bit slot (phase / 3) and step within the slot.
    typedef struct packed {
        logic [3:0] slot;
        logic [1:0] step;
    } phase_split_t;

    // Small table: divide a 5-bit phase by three.
    function automatic phase_split_t split_phase(input logic [4:0] ph);
        phase_split_t s;
        case (ph)
            5'd0,  5'd1,  5'd2:  s.slot = 4'd0;
            5'd3,  5'd4,  5'd5:  s.slot = 4'd1;
            5'd6,  5'd7,  5'd8:  s.slot = 4'd2;
            5'd9,  5'd10, 5'd11: s.slot = 4'd3;
            5'd12, 5'd13, 5'd14: s.slot = 4'd4;
            5'd15, 5'd16, 5'd17: s.slot = 4'd5;
            5'd18, 5'd19, 5'd20: s.slot = 4'd6;
            5'd21, 5'd22, 5'd23: s.slot = 4'd7;
            5'd24, 5'd25, 5'd26: s.slot = 4'd8;
            5'd27, 5'd28, 5'd29: s.slot = 4'd9;
            5'd30, 5'd31:        s.slot = 4'd10;
            default:             s.slot = 4'd0;
        endcase
        s.step = 2'(ph - 5'(s.slot) * 5'd3);
        return s;
    endfunction

endpackage

FILE: src/i2cms_ram.sv
// ----------------------------------------------------------------------------
// Generic buffer RAM
// One write port and two read ports, each read with enable and registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic                     re_b,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports return the contents from before a same-cycle write.
    always_ff @(posedge clk) begin
        if (re_a) begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b) begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: src/i2c_master_bitbang_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master bit-bang sequencer
// Tick-driven I2C master: drives SCL and SDA one timer tick per word.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                        Word
//   input     s_valid s_ready s_data       kind, sda_in, buffer_index, buffer_byte
//   result    m_valid m_ready m_data       line levels, status, readback byte
//   config    cfg_we cfg_index cfg_wdata   byte_count (0), read_mode (1)
//
// One word is accepted per cycle while s_ready is high; its result word goes
// through the middle stage and the output register. State update and RAM read
// of the readback byte happen at the accept edge; the byte joins the status in
// the output register. The current transfer byte is read on a second RAM port
// every cycle, with a bypass of the most recent write. Reset is synchronous,
// active low, and needs no clearing pass. A stalled output holds one word in
// the output register and one in the middle stage before s_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_bitbang_sequencer
    import i2cms_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    // Configuration registers.
    logic [CFG_DW-1:0] byte_count_reg;
    logic              read_mode_reg;

    // Sequencer state.
    logic [4:0]  tick_phase_reg, tick_phase_next;
    logic [7:0]  byte_index_reg, byte_index_next;
    logic        running_reg, running_next;
    logic        finished_reg, finished_next;
    logic [1:0]  fault_reg, fault_next;
    logic        scl_level_reg, scl_level_next;
    logic        sda_level_reg, sda_level_next;

    // Buffer RAM signals and the write bypass.
    logic              ram_we;
    logic [BUF_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata_a;
    logic [7:0]        ram_rdata_b;
    logic [BUF_AW-1:0] ram_raddr_b;
    logic              wr_last_valid_reg;
    logic [BUF_AW-1:0] wr_last_addr_reg;
    logic [7:0]        wr_last_data_reg;

    // Output path.
    logic        p1_valid_reg, p1_valid_next;
    logic        p1_rd_reg;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg;
    logic        in_fire;
    logic        p1_adv;

    // Tick helpers.
    logic [7:0]   cur_byte;
    logic [7:0]   last_index;
    logic         last_byte;
    phase_split_t ph;
    logic [2:0]   addr_bit;
    logic [2:0]   data_bit;
    logic         idx_in_range;
    logic         cur_in_range;

    assign in_fire  = s_valid && s_ready;
    assign p1_adv   = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !p1_valid_reg || p1_adv;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= CFG_DW'(1);
            read_mode_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_BYTE_COUNT: byte_count_reg <= cfg_wdata;
                CFG_READ_MODE:  read_mode_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Index of the last byte, with the count clamped to the buffer.
    always_comb begin
        if (byte_count_reg == '0) begin
            last_index = 8'd0;
        end else if (byte_count_reg > CFG_DW'(BUF_DEPTH)) begin
            last_index = 8'(BUF_DEPTH - 1);
        end else begin
            last_index = 8'(byte_count_reg - CFG_DW'(1));
        end
    end

    assign last_byte    = byte_index_reg >= last_index;
    assign ph           = split_phase(tick_phase_reg);
    assign addr_bit     = 3'(4'd8 - ph.slot);
    assign data_bit     = 3'(4'd7 - ph.slot);
    assign idx_in_range = {1'b0, s_data.buffer_index} < 9'(BUF_DEPTH);
    assign cur_in_range = {1'b0, byte_index_reg} < 9'(BUF_DEPTH);

    // Current transfer byte: RAM data, or the write made at the last edge.
    assign cur_byte = (wr_last_valid_reg && wr_last_addr_reg == byte_index_reg[BUF_AW-1:0])
                      ? wr_last_data_reg : ram_rdata_b;

    // Next state of the sequencer for the accepted word.
    always_comb begin
        tick_phase_next = tick_phase_reg;
        byte_index_next = byte_index_reg;
        running_next    = running_reg;
        finished_next   = finished_reg;
        fault_next      = fault_reg;
        scl_level_next  = scl_level_reg;
        sda_level_next  = sda_level_reg;
        ram_we          = 1'b0;
        ram_waddr       = s_data.buffer_index[BUF_AW-1:0];
        ram_wdata       = s_data.buffer_byte;

        if (in_fire) begin
            case (s_data.kind)
                KIND_TICK: begin
                    if (running_reg) begin
                        tick_phase_next = tick_phase_reg + 5'd1;
                        if (byte_index_reg == 8'd0) begin
                            // Start condition, address byte, its acknowledge and a stop if the transfer ends here.
                            if (tick_phase_reg == 5'd0) begin
                                scl_level_next = 1'b1;
                                sda_level_next = 1'b1;
                            end else if (tick_phase_reg == 5'd1) begin
                                sda_level_next = 1'b0;
                            end else if (tick_phase_reg == 5'd2) begin
                                scl_level_next = 1'b0;
                            end else if (tick_phase_reg < PH_ADDR_BITS_END) begin
                                if (ph.step == 2'd0) begin
                                    scl_level_next = 1'b0;
                                    sda_level_next = cur_byte[addr_bit];
                                end else if (ph.step == 2'd1) begin
                                    scl_level_next = 1'b1;
                                end else begin
                                    scl_level_next = 1'b0;
                                end
                            end else if (tick_phase_reg == PH_ADDR_BITS_END) begin
                                sda_level_next = 1'b1;
                                scl_level_next = 1'b1;
                            end else if (tick_phase_reg == 5'd28) begin
                                if (s_data.sda_in) begin
                                    fault_next = ERR_ADDR;
                                end
                            end else if (tick_phase_reg == PH_ADDR_ACK_END) begin
                                scl_level_next = 1'b0;
                                if (fault_reg != ERR_NONE || last_byte) begin
                                    sda_level_next = 1'b0;
                                end else begin
                                    sda_level_next  = read_mode_reg;
                                    byte_index_next = 8'd1;
                                    tick_phase_next = 5'd0;
                                end
                            end else if (tick_phase_reg == 5'd30) begin
                                scl_level_next = 1'b1;
                            end else begin
                                sda_level_next  = 1'b1;
                                running_next    = 1'b0;
                                finished_next   = 1'b1;
                                byte_index_next = 8'd0;
                                tick_phase_next = 5'd0;
                            end
                        end else if (!read_mode_reg) begin
                            // Data byte written to the slave, its ACK, and a stop after the last byte or a NACK.
                            if (tick_phase_reg < PH_DATA_BITS_END) begin
                                if (ph.step == 2'd0) begin
                                    scl_level_next = 1'b0;
                                    sda_level_next = cur_byte[data_bit];
                                end else if (ph.step == 2'd1) begin
                                    scl_level_next = 1'b1;
                                end else begin
                                    scl_level_next = 1'b0;
                                end
                            end else if (tick_phase_reg == PH_DATA_BITS_END) begin
                                sda_level_next = 1'b1;
                                scl_level_next = 1'b1;
                            end else if (tick_phase_reg == 5'd25) begin
                                if (s_data.sda_in) begin
                                    fault_next      = ERR_DATA;
                                    byte_index_next = last_index;
                                    tick_phase_next = PH_ADDR_BITS_END;
                                end
                            end else if (tick_phase_reg == 5'd26) begin
                                scl_level_next = 1'b0;
                                sda_level_next = 1'b0;
                            end else if (tick_phase_reg == PH_ADDR_BITS_END) begin
                                if (last_byte) begin
                                    scl_level_next = 1'b0;
                                    sda_level_next = 1'b0;
                                end else begin
                                    byte_index_next = byte_index_reg + 8'd1;
                                    tick_phase_next = 5'd0;
                                end
                            end else if (tick_phase_reg == 5'd28) begin
                                scl_level_next = 1'b1;
                            end else if (tick_phase_reg == PH_ADDR_ACK_END) begin
                                sda_level_next  = 1'b1;
                                running_next    = 1'b0;
                                finished_next   = 1'b1;
                                byte_index_next = 8'd0;
                                tick_phase_next = 5'd0;
                            end
                        end else begin
                            // Slave byte read bit by bit into the buffer; ACK, or NACK and stop on the last byte.
                            if (tick_phase_reg < PH_DATA_BITS_END) begin
                                if (ph.step == 2'd0) begin
                                    scl_level_next = 1'b1;
                                    sda_level_next = 1'b1;
                                end else if (ph.step == 2'd1) begin
                                    ram_we              = cur_in_range;
                                    ram_waddr           = byte_index_reg[BUF_AW-1:0];
                                    ram_wdata           = cur_byte;
                                    ram_wdata[data_bit] = s_data.sda_in;
                                end else begin
                                    scl_level_next = 1'b0;
                                end
                            end else if (tick_phase_reg == PH_DATA_BITS_END) begin
                                sda_level_next = last_byte;
                            end else if (tick_phase_reg == 5'd25) begin
                                scl_level_next = 1'b1;
                            end else if (tick_phase_reg == 5'd26) begin
                                scl_level_next = 1'b0;
                            end else if (tick_phase_reg == PH_ADDR_BITS_END) begin
                                sda_level_next = !last_byte;
                            end else if (tick_phase_reg == 5'd28) begin
                                if (last_byte) begin
                                    scl_level_next = 1'b1;
                                end else begin
                                    byte_index_next = byte_index_reg + 8'd1;
                                    tick_phase_next = 5'd0;
                                end
                            end else if (tick_phase_reg == PH_ADDR_ACK_END) begin
                                sda_level_next  = 1'b1;
                                running_next    = 1'b0;
                                finished_next   = 1'b1;
                                byte_index_next = 8'd0;
                                tick_phase_next = 5'd0;
                            end
                        end
                    end
                end
                KIND_START: begin
                    if (!running_reg) begin
                        running_next    = 1'b1;
                        finished_next   = 1'b0;
                        fault_next      = ERR_NONE;
                        tick_phase_next = 5'd0;
                        byte_index_next = 8'd0;
                    end
                end
                KIND_LOAD: begin
                    ram_we = idx_in_range;
                end
                default: ;
            endcase
        end
    end

    // Sequencer state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_phase_reg    <= 5'd0;
            byte_index_reg    <= 8'd0;
            running_reg       <= 1'b0;
            finished_reg      <= 1'b0;
            fault_reg         <= ERR_NONE;
            scl_level_reg     <= 1'b1;
            sda_level_reg     <= 1'b1;
            wr_last_valid_reg <= 1'b0;
        end else begin
            tick_phase_reg    <= tick_phase_next;
            byte_index_reg    <= byte_index_next;
            running_reg       <= running_next;
            finished_reg      <= finished_next;
            fault_reg         <= fault_next;
            scl_level_reg     <= scl_level_next;
            sda_level_reg     <= sda_level_next;
            wr_last_valid_reg <= ram_we;
        end
    end

    // Bypass copy of the latest buffer write.
    always_ff @(posedge aclk) begin
        wr_last_addr_reg <= ram_waddr;
        wr_last_data_reg <= ram_wdata;
    end

    // The second read port follows the byte index the sequencer moves to.
    assign ram_raddr_b = aresetn ? byte_index_next[BUF_AW-1:0] : '0;

    i2cms_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .clk     (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re_a    (in_fire),
        .raddr_a (s_data.buffer_index[BUF_AW-1:0]),
        .rdata_a (ram_rdata_a),
        .re_b    (1'b1),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    // Output path control: middle stage and output register.
    always_comb begin
        p1_valid_next = in_fire || (p1_valid_reg && !p1_adv);
        m_valid_next  = p1_adv || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // The middle stage reads status straight from the state registers,
    // which hold until it moves on.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            p1_rd_reg <= (s_data.kind == KIND_READ) && idx_in_range;
        end
        if (p1_adv) begin
            m_data_reg.scl_out     <= scl_level_reg;
            m_data_reg.sda_out     <= sda_level_reg;
            m_data_reg.busy_res    <= running_reg;
            m_data_reg.done_res    <= finished_reg;
            m_data_reg.error_code  <= fault_reg;
            m_data_reg.buffer_read <= p1_rd_reg ? ram_rdata_a : 8'd0;
        end
    end

`ifndef SYNTH
    // A transfer is never both running and finished.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(running_reg && finished_reg))
        else $error("busy and done both set");

    // An idle sequencer rests at phase zero on the address byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> (tick_phase_reg == 5'd0 && byte_index_reg == 8'd0))
        else $error("idle sequencer left a phase or byte index behind");

    // Data bytes never run past the stop phases.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (running_reg && byte_index_reg != 8'd0) |-> tick_phase_reg <= PH_ADDR_ACK_END)
        else $error("data byte phase out of range");

    // An address NACK stays on the address byte until the stop.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (running_reg && fault_reg == ERR_ADDR) |-> byte_index_reg == 8'd0)
        else $error("address NACK moved to a data byte");
`endif

endmodule
